// ===== src/psd_pkg.sv =====
`timescale 1ns / 1ps
package psd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 32;
  localparam int DIST_BITS  = 17 + FRAC_BITS;

  // coordinate difference, product, sum widths
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int CW = PW + 1;
  // half of the cross product magnitude for split squaring
  localparam int HW = (CW + 1) / 2;
  localparam int NW = 4 * HW;
  // remainder / trial term width in the root cells
  localparam int QW = CW + 2 * DIST_BITS;
  localparam int EW = (NW > QW) ? NW + 2 : QW + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_BITS-1:0]         dist_t;

  typedef struct packed {
    logic              vld;
    logic              degen;
    logic [EW-1:0]     rem;
    logic [EW-1:0]     lin;
    logic [EW-1:0]     quad;
    dist_t             root;
  } psd_cell_t;

endpackage

// ===== src/psd_if.sv =====
`timescale 1ns / 1ps
interface psd_in_if;
  import psd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t seg_start_x;
  coord_t seg_start_y;
  coord_t seg_end_x;
  coord_t seg_end_y;
  coord_t point_x;
  coord_t point_y;
  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  point_x, point_y, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                point_x, point_y, output ready);
endinterface

interface psd_out_if;
  import psd_pkg::*;
  logic  valid;
  logic  ready;
  dist_t distance;
  logic  degenerate;
  modport source (output valid, distance, degenerate, input ready);
  modport sink (input valid, distance, degenerate, output ready);
endinterface

// ===== src/psd_front.sv =====
`timescale 1ns / 1ps
module psd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  psd_pkg::coord_t     x1,
  input  psd_pkg::coord_t     y1,
  input  psd_pkg::coord_t     x2,
  input  psd_pkg::coord_t     y2,
  input  psd_pkg::coord_t     px,
  input  psd_pkg::coord_t     py,
  output psd_pkg::psd_cell_t  head
);
  import psd_pkg::*;

  // stage 1: differences
  logic v1;
  logic signed [DW-1:0] ex, ey, qx, qy, rx, ry;
  // stage 2: products
  logic v2;
  logic signed [PW-1:0] pxx, pyy, pdx, pdy, pqx, pqy, prx, pry, pcx, pcy;
  // stage 3: sums
  logic v3;
  logic [CW-1:0] len2, nq, nr;
  logic signed [CW-1:0] dot, crs;
  // stage 4: case select and split squaring
  logic v4, degen4, inner4;
  logic [2*HW-1:0] hh, hl, ll;
  logic [CW-1:0] nsel, lsel;

  logic degen_c, lo_c, hi_c, inner_c;
  logic [2*HW-1:0] cmag;
  logic [HW-1:0] chi, clo;
  logic [NW-1:0] nfull;

  function automatic logic signed [DW-1:0] sx(input coord_t a);
    sx = {a[COORD_BITS-1], a};
  endfunction

  assign degen_c = (len2 == '0);
  assign lo_c    = degen_c || dot[CW-1] || (dot == '0);
  assign hi_c    = (dot >= $signed(len2));
  assign inner_c = !lo_c && !hi_c;
  assign cmag    = crs[CW-1] ? (2*HW)'(-crs) : (2*HW)'(crs);
  assign chi     = cmag[2*HW-1:HW];
  assign clo     = cmag[HW-1:0];

  assign nfull = inner4
      ? (NW'(hh) << (2*HW)) + (NW'(hl) << (HW + 1)) + NW'(ll)
      : NW'(nsel);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      head.vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      head.vld <= v4;
    end
    if (en) begin
      ex <= sx(x2) - sx(x1);
      ey <= sx(y2) - sx(y1);
      qx <= sx(px) - sx(x1);
      qy <= sx(py) - sx(y1);
      rx <= sx(px) - sx(x2);
      ry <= sx(py) - sx(y2);

      pxx <= ex * ex;
      pyy <= ey * ey;
      pdx <= qx * ex;
      pdy <= qy * ey;
      pqx <= qx * qx;
      pqy <= qy * qy;
      prx <= rx * rx;
      pry <= ry * ry;
      pcx <= qx * ey;
      pcy <= qy * ex;

      len2 <= CW'(pxx) + CW'(pyy);
      nq   <= CW'(pqx) + CW'(pqy);
      nr   <= CW'(prx) + CW'(pry);
      dot  <= {pdx[PW-1], pdx} + {pdy[PW-1], pdy};
      crs  <= {pcx[PW-1], pcx} - {pcy[PW-1], pcy};

      degen4 <= degen_c;
      inner4 <= inner_c;
      hh     <= chi * chi;
      hl     <= chi * clo;
      ll     <= clo * clo;
      nsel   <= lo_c ? nq : nr;
      lsel   <= inner_c ? len2 : CW'(1);

      head.degen <= degen4;
      head.rem   <= EW'(nfull);
      head.lin   <= '0;
      head.quad  <= EW'(lsel) << (2 * (DIST_BITS - 1));
      head.root  <= '0;
    end
  end

endmodule

// ===== src/psd_cell.sv =====
`timescale 1ns / 1ps
module psd_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  psd_pkg::psd_cell_t prev,
  output psd_pkg::psd_cell_t cur
);
  import psd_pkg::*;

  logic [EW-1:0] trial;
  logic          take;

  // trial = (r*l << (b+1)) + (l << 2b) is the growth of r^2*l when bit b is set
  assign trial = prev.lin + prev.quad;
  assign take  = (trial <= prev.rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else if (en) begin
      cur.vld <= prev.vld;
    end
    if (en) begin
      cur.degen <= prev.degen;
      cur.rem   <= take ? prev.rem - trial : prev.rem;
      cur.lin   <= (prev.lin >> 1) + (take ? prev.quad : '0);
      cur.quad  <= prev.quad >> 2;
      cur.root  <= {prev.root[DIST_BITS-2:0], take};
    end
  end

endmodule

// ===== src/point_segment_distance.sv =====
`timescale 1ns / 1ps
// point to segment distance, 2-d, signed fixed-point coordinates.
// one beat in carries segment start, segment end and query point; one beat out
// carries the distance to the nearest point of the segment, rounded down, plus
// a flag for a zero-length segment (distance then measured to the start). a new
// beat is taken every cycle unless the output stalls. five front stages form
// differences, products, dot/cross/length sums and the exact squared numerator,
// then a row of DIST_BITS cells finds the root one result bit per cell, msb
// first, with shifts, three wide adds or subtracts and one compare each. the
// whole pipe moves together and halts only while a finished result waits at
// the output.
module point_segment_distance (
  input logic      clk,
  input logic      rst,
  psd_in_if.sink   in_ch,
  psd_out_if.source out_ch
);
  import psd_pkg::*;

  psd_cell_t chain [DIST_BITS+1];
  logic      en;

  // the last cell register is the output register
  assign en          = !chain[DIST_BITS].vld || out_ch.ready;
  assign in_ch.ready = en;

  psd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_ch.valid),
    .x1     (in_ch.seg_start_x),
    .y1     (in_ch.seg_start_y),
    .x2     (in_ch.seg_end_x),
    .y2     (in_ch.seg_end_y),
    .px     (in_ch.point_x),
    .py     (in_ch.point_y),
    .head   (chain[0])
  );

  // one cell per result bit, msb first
  for (genvar i = 0; i < DIST_BITS; i++) begin : g_cell
    psd_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .prev (chain[i]),
      .cur  (chain[i+1])
    );
  end

  assign out_ch.valid      = chain[DIST_BITS].vld;
  assign out_ch.distance   = chain[DIST_BITS].root;
  assign out_ch.degenerate = chain[DIST_BITS].degen;

endmodule

// ===== src/psd_checker.sv =====
`timescale 1ns / 1ps
module psd_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input psd_pkg::dist_t    distance,
  input logic              degenerate
);

  // pipe halts only for a waiting result
  a_ready: assert property (@(posedge clk) disable iff (rst)
      in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(degenerate))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .distance   (out_ch.distance),
  .degenerate (out_ch.degenerate)
);
